FILE: rtl/assert_macros.svh
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: label, clock, active-low reset, property
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// default clock and reset of this project
`define ASSERT_CLK(lbl, prop) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/bis_pkg.sv
// Package of the bilinear image sampler: payload types, codes and defaults.
package bis_pkg;

  localparam int MaxColsDef  = 512;
  localparam int MaxRowsDef  = 512;
  localparam int FracBitsDef = 8;

  localparam int PosW = 17;
  localparam int PixW = 8;
  localparam int OutW = 24;
  localparam int DimW = 10;
  localparam int ApbW = 32;

  localparam logic [DimW-1:0] DimReset       = 10'd512;
  localparam logic [OutW-1:0] MaxSampleValue = 24'hFF0000;

  localparam logic FuncLoad      = 1'b0;
  localparam logic FuncSample    = 1'b1;
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusOutside = 1'b1;
  localparam logic RegIdxWidth   = 1'b0;
  localparam logic RegIdxHeight  = 1'b1;

  typedef struct packed {
    logic            func;
    logic [PixW-1:0] pixel_value;
    logic [PosW-1:0] x_pos;
    logic [PosW-1:0] y_pos;
  } bis_cmd_t;

  typedef struct packed {
    logic [OutW-1:0] sample_value;
    logic            sample_status;
  } bis_res_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } bis_step_t;

endpackage

FILE: rtl/bis_pix_mem.sv
// Pixel store: one write port, one read port, registered read data.
module bis_pix_mem #(
  parameter int Depth = bis_pkg::MaxColsDef * bis_pkg::MaxRowsDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [bis_pkg::PixW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [bis_pkg::PixW-1:0] rdata_o
);
  import bis_pkg::*;

  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bis_blend.sv
// Blend unit: weight product, pixel product, accumulation and output scaling.
module bis_blend #(
  parameter int FracBits = bis_pkg::FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bis_pkg::bis_step_t       step_i,
  input  logic [FracBits:0]        wx_i,
  input  logic [FracBits:0]        wy_i,
  input  logic [bis_pkg::PixW-1:0] pix_i,
  output logic                     done_o,
  output logic [bis_pkg::OutW-1:0] value_o
);
  import bis_pkg::*;

  localparam int WtW = 2 * FracBits + 1;
  localparam int AccW = 2 * FracBits + PixW;
  localparam int ShL = (2 * FracBits <= 16) ? 16 - 2 * FracBits : 0;
  localparam int ShR = (2 * FracBits > 16) ? 2 * FracBits - 16 : 1;

  bis_step_t s1_q, s2_q;
  logic [WtW-1:0]  weight_q;
  logic [AccW-1:0] prod_q, acc_q, acc_sum;
  logic [OutW-1:0] scaled, value_q;
  logic            done_q;

  assign acc_sum = (s2_q.first ? '0 : acc_q) + prod_q;

  if (2 * FracBits <= 16) begin : g_shl
    assign scaled = OutW'(acc_sum) << ShL;
  end else begin : g_shr
    logic [AccW:0] rnd;
    assign rnd    = {1'b0, acc_sum} + (AccW+1)'(1 << (ShR - 1));
    assign scaled = OutW'(rnd >> ShR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= step_i;
      s2_q   <= s1_q;
      done_q <= s2_q.valid && s2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q <= WtW'(WtW'(wx_i) * WtW'(wy_i));
    prod_q   <= AccW'(AccW'(weight_q) * AccW'(pix_i));
    if (s2_q.valid) begin
      acc_q <= acc_sum;
    end
    if (s2_q.valid && s2_q.last) begin
      value_q <= scaled;
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

FILE: rtl/bilinear_image_sampler_core.sv
// Top level of the bilinear image sampler: control, size registers, APB port.
//
//   channel   direction  handshake            word
//   command   in         start / busy         cmd_i (func, pixel_value, x_pos, y_pos)
//   result    out        done_o strobe        result_o (sample_value, sample_status)
//   config    in/out     APB psel/penable     image_width, image_height
//
// Load: one store write between accept and the next accept.
// Sample inside the image: the single store read port gives one
// neighbor per cycle, then a 3-stage multiply/accumulate.
// Sample with a neighbor outside: result flagged, value zero.
// The result strobe lasts one cycle and cannot be stalled; the next command
// may be accepted in that cycle. Reset leaves the pixel store as it was.
module bilinear_image_sampler_core #(
  parameter int MaxCols  = bis_pkg::MaxColsDef,
  parameter int MaxRows  = bis_pkg::MaxRowsDef,
  parameter int FracBits = bis_pkg::FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  bis_pkg::bis_cmd_t        cmd_i,
  output logic                     done_o,
  output bis_pkg::bis_res_t        result_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [bis_pkg::ApbW-1:0] pwdata,
  output logic [bis_pkg::ApbW-1:0] prdata,
  output logic                     pready
);
  import bis_pkg::*;

  localparam int ColW  = $clog2(MaxCols);
  localparam int RowW  = $clog2(MaxRows);
  localparam int Depth = MaxCols * MaxRows;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StCheck,
    StRead,
    StWait
  } state_e;

  state_e          state_q;
  logic [1:0]      cnt_q;
  logic            res_valid_q;
  bis_res_t        res_q;
  bis_cmd_t        cmd_q;
  logic [AddrW-1:0] base_q, base_d, raddr;
  logic [DimW-1:0] width_q, height_q;

  logic [PosW-1:0] col, row, w_eff, h_eff;
  logic            in_img, edge_out;
  logic [FracBits-1:0] fx, fy;
  logic [FracBits:0]   gx, gy, wx, wy;
  bis_step_t       step;
  logic [PixW-1:0] pix;
  logic            blend_done;
  logic [OutW-1:0] blend_value;

  // geometry
  assign col   = PosW'(cmd_q.x_pos >> FracBits);
  assign row   = PosW'(cmd_q.y_pos >> FracBits);
  assign w_eff = (PosW'(width_q) < PosW'(MaxCols)) ? PosW'(width_q) : PosW'(MaxCols);
  assign h_eff = (PosW'(height_q) < PosW'(MaxRows)) ? PosW'(height_q) : PosW'(MaxRows);
  assign in_img = (col < w_eff) && (row < h_eff);
  assign edge_out = ((PosW+1)'(col) + (PosW+1)'(1) >= (PosW+1)'(w_eff)) ||
                    ((PosW+1)'(row) + (PosW+1)'(1) >= (PosW+1)'(h_eff));
  assign base_d = AddrW'(AddrW'(row[RowW-1:0]) * AddrW'(MaxCols)) +
                  AddrW'(col[ColW-1:0]);
  assign raddr  = base_q + (cnt_q[1] ? AddrW'(MaxCols) : '0) + AddrW'(cnt_q[0]);

  // weights: neighbor order (r,c) (r,c+1) (r+1,c) (r+1,c+1)
  assign fx = cmd_q.x_pos[FracBits-1:0];
  assign fy = cmd_q.y_pos[FracBits-1:0];
  assign gx = (FracBits+1)'(1 << FracBits) - {1'b0, fx};
  assign gy = (FracBits+1)'(1 << FracBits) - {1'b0, fy};
  assign wx = cnt_q[0] ? {1'b0, fx} : gx;
  assign wy = cnt_q[1] ? {1'b0, fy} : gy;

  assign step.valid = (state_q == StRead);
  assign step.first = (cnt_q == 2'd0);
  assign step.last  = (cnt_q == 2'd3);

  bis_pix_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    ((state_q == StLoad) && in_img),
    .waddr_i (base_d),
    .wdata_i (cmd_q.pixel_value),
    .re_i    (step.valid),
    .raddr_i (raddr),
    .rdata_o (pix)
  );

  bis_blend #(
    .FracBits (FracBits)
  ) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .wx_i    (wx),
    .wy_i    (wy),
    .pix_i   (pix),
    .done_o  (blend_done),
    .value_o (blend_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start) begin
            state_q <= (cmd_i.func == FuncSample) ? StCheck : StLoad;
          end
        end
        StLoad: state_q <= StIdle;
        StCheck: begin
          cnt_q <= '0;
          if (edge_out) begin
            res_valid_q          <= 1'b1;
            res_q.sample_value   <= '0;
            res_q.sample_status  <= StatusOutside;
            state_q              <= StIdle;
          end else begin
            state_q <= StRead;
          end
        end
        StRead: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= StWait;
          end
        end
        StWait: begin
          if (blend_done) begin
            res_valid_q         <= 1'b1;
            res_q.sample_value  <= blend_value;
            res_q.sample_status <= StatusOk;
            state_q             <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
    if (state_q == StCheck) begin
      base_q <= base_d;
    end
  end

  // size registers, decoded on paddr[2]
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimReset;
      height_q <= DimReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegIdxHeight) begin
        height_q <= pwdata[DimW-1:0];
      end else begin
        width_q <= pwdata[DimW-1:0];
      end
    end
  end

  assign prdata   = ApbW'((paddr[2] == RegIdxHeight) ? height_q : width_q);
  assign pready   = 1'b1;
  assign busy     = (state_q != StIdle);
  assign done_o   = res_valid_q;
  assign result_o = res_q;

endmodule

FILE: rtl/bis_checker.sv
// Port-level checker for the bilinear image sampler, bound to the top level.
`include "assert_macros.svh"

module bis_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input bis_pkg::bis_res_t result_o
);
  import bis_pkg::*;

  `ASSERT_CLK(a_outside_zero,
    done_o && (result_o.sample_status == StatusOutside) |-> result_o.sample_value == '0)
  `ASSERT_CLK(a_value_max, done_o |-> result_o.sample_value <= MaxSampleValue)
  `ASSERT_CLK(a_accept_busy, start && !busy |=> busy)
  `ASSERT_CLK(a_done_idle, done_o |-> !busy)
  `ASSERT_CLK(a_done_single, done_o |=> !done_o)

endmodule

bind bilinear_image_sampler_core bis_checker u_bis_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the bilinear image sampler core.
`timescale 1ns / 100ps

module tb_top;
  import bis_pkg::*;

  localparam int FB         = FracBitsDef;
  localparam int StoreDepth = MaxColsDef * MaxRowsDef;
  localparam int PhaseItems = 185;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic            func;
    logic [PixW-1:0] pix;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic            typed;
    logic [OutW-1:0] val;
    logic            status;
  } dir_row_t;

  logic            clk_i   = 1'b0;
  logic            rst_ni  = 1'b0;
  logic            start   = 1'b0;
  bis_cmd_t        cmd_i   = '0;
  logic            psel    = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite  = 1'b0;
  logic [2:0]      paddr   = '0;
  logic [ApbW-1:0] pwdata  = '0;
  logic            busy;
  logic            done_o;
  bis_res_t        result_o;
  logic [ApbW-1:0] prdata;
  logic            pready;

  logic [PixW-1:0] img_mem     [StoreDepth];
  bit              img_written [StoreDepth];
  logic [DimW-1:0] width_cfg;
  logic [DimW-1:0] height_cfg;
  bis_res_t        pending_samples [$];
  int              errors     = 0;
  int              items_sent = 0;
  int              cycles     = 0;
  bit              idle_on    = 1'b1;

  bilinear_image_sampler_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void log_mismatch(string what, longint unsigned e, longint unsigned a);
    errors++;
    if (errors <= 10) $display("mismatch in %s: expected %0h, got %0h", what, e, a);
  endfunction

  function automatic int unsigned img_w();
    return (width_cfg < MaxColsDef) ? width_cfg : MaxColsDef;
  endfunction

  function automatic int unsigned img_h();
    return (height_cfg < MaxRowsDef) ? height_cfg : MaxRowsDef;
  endfunction

  function automatic bit pos_in_image(input bis_cmd_t c);
    return ((c.x_pos >> FB) < img_w()) && ((c.y_pos >> FB) < img_h());
  endfunction

  // Returns 1 when the word yields a sample; loads update the image copy.
  function automatic bit predict_blend(input bis_cmd_t c, output bis_res_t r);
    int unsigned      col, row, a;
    longint unsigned  fx, fy, gx, gy, sum;
    col = c.x_pos >> FB;
    row = c.y_pos >> FB;
    r = '0;
    if (c.func == FuncLoad) begin
      if (pos_in_image(c)) begin
        a = row * MaxColsDef + col;
        img_mem[a] = c.pixel_value;
        img_written[a] = 1'b1;
      end
      return 1'b0;
    end
    if (col + 1 >= img_w() || row + 1 >= img_h()) begin
      r.sample_status = StatusOutside;
      return 1'b1;
    end
    a  = row * MaxColsDef + col;
    fx = c.x_pos & ((1 << FB) - 1);
    fy = c.y_pos & ((1 << FB) - 1);
    gx = (1 << FB) - fx;
    gy = (1 << FB) - fy;
    sum = gy * gx * img_mem[a] + gy * fx * img_mem[a + 1]
        + fy * gx * img_mem[a + MaxColsDef] + fy * fx * img_mem[a + MaxColsDef + 1];
    if (2 * FB <= 16) sum = sum << (16 - 2 * FB);
    else sum = (sum + (64'd1 << (2 * FB - 17))) >> (2 * FB - 16);
    r.sample_value  = sum[OutW-1:0];
    r.sample_status = StatusOk;
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic issue(input bis_cmd_t c, input bit use_typed, input bis_res_t typed_res);
    bis_res_t r;
    bit       has;
    while (idle_on && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    has = predict_blend(c, r);
    if (has) pending_samples.push_back(use_typed ? typed_res : r);
    if (c.func == FuncSample || pos_in_image(c)) items_sent++;
    @(negedge clk_i);
  endtask

  // Loads any missing neighbor first so no unwritten pixel is ever read.
  task automatic sample_at(input bis_cmd_t c);
    int unsigned col, row;
    bis_cmd_t    ld;
    col = c.x_pos >> FB;
    row = c.y_pos >> FB;
    if (c.func == FuncSample && col + 1 < img_w() && row + 1 < img_h()) begin
      for (int dy = 0; dy < 2; dy++) begin
        for (int dx = 0; dx < 2; dx++) begin
          if (!img_written[(row + dy) * MaxColsDef + col + dx]) begin
            ld.func        = FuncLoad;
            ld.pixel_value = $urandom;
            ld.x_pos       = PosW'(((col + dx) << FB) | $urandom_range((1 << FB) - 1));
            ld.y_pos       = PosW'(((row + dy) << FB) | $urandom_range((1 << FB) - 1));
            issue(ld, 1'b0, '0);
          end
        end
      end
    end
    issue(c, 1'b0, '0);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [DimW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (ApbW'($urandom) & ~ApbW'(10'h3FF)) | ApbW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegIdxWidth) width_cfg = val;
    else height_cfg = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic cfg_check(input logic idx, input logic [DimW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[DimW-1:0] !== want) log_mismatch("register readback", want, prdata[DimW-1:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n);
    int unsigned w, h, ox, oy, col, row, sel, fx, fy;
    int          base;
    bit          paused;
    bis_cmd_t    c;
    base   = items_sent;
    paused = 1'b0;
    w  = img_w();
    h  = img_h();
    ox = (w > 8) ? $urandom_range(w - 8) : 0;
    oy = (h > 8) ? $urandom_range(h - 8) : 0;
    while (items_sent - base < n) begin
      sel = $urandom_range(99);
      col = ox + $urandom_range(7);
      row = oy + $urandom_range(7);
      fx  = $urandom_range((1 << FB) - 1);
      fy  = $urandom_range((1 << FB) - 1);
      case ($urandom_range(9))
        0: fx = 0;
        1: fy = (1 << FB) - 1;
        2: begin
          fx = (1 << FB) - 1;
          fy = 0;
        end
        default: ;
      endcase
      if (sel >= 80 && sel < 90) begin
        if ($urandom_range(1)) col = (w >= 2) ? w - 2 + $urandom_range(1) : 0;
        else row = (h >= 2) ? h - 2 + $urandom_range(1) : 0;
      end
      c.func        = (sel < 35) ? FuncLoad : FuncSample;
      c.pixel_value = $urandom;
      c.x_pos       = PosW'((col << FB) | fx);
      c.y_pos       = PosW'((row << FB) | fy);
      if ((sel >= 25 && sel < 35) || sel >= 90) begin
        c.x_pos = $urandom;
        c.y_pos = $urandom;
      end
      if (!paused && items_sent - base >= n / 2) begin
        paused = 1'b1;
        drain();
      end
      sample_at(c);
    end
  endtask

  initial begin
    dir_row_t dir_rows [21];
    int       ph_w [8];
    int       ph_h [8];
    bis_cmd_t c;
    bis_res_t tr;
    ph_w = '{512, 2, 1023, 512, 2, 0, -1, -1};
    ph_h = '{512, 2, 1023, 2, 512, 300, -1, -1};
    dir_rows = '{
      '{FuncLoad,   8'hFF, 17'h00000, 17'h00000, 1'b0, 24'h0,     StatusOk},
      '{FuncLoad,   8'hFF, 17'h00100, 17'h00000, 1'b0, 24'h0,     StatusOk},
      '{FuncLoad,   8'hFF, 17'h00000, 17'h00100, 1'b0, 24'h0,     StatusOk},
      '{FuncLoad,   8'hFF, 17'h001FF, 17'h001FF, 1'b0, 24'h0,     StatusOk},
      '{FuncSample, 8'h00, 17'h00000, 17'h00000, 1'b1, 24'hFF0000, StatusOk},
      '{FuncSample, 8'hFF, 17'h000FF, 17'h000FF, 1'b1, 24'hFF0000, StatusOk},
      '{FuncLoad,   8'h00, 17'h00200, 17'h00000, 1'b0, 24'h0,     StatusOk},
      '{FuncLoad,   8'h00, 17'h00200, 17'h00100, 1'b0, 24'h0,     StatusOk},
      '{FuncSample, 8'h5A, 17'h00180, 17'h00000, 1'b0, 24'h0,     StatusOk},
      '{FuncSample, 8'hA5, 17'h001FF, 17'h000FF, 1'b0, 24'h0,     StatusOk},
      '{FuncSample, 8'h00, 17'h1FF00, 17'h00000, 1'b1, 24'h0,     StatusOutside},
      '{FuncSample, 8'h00, 17'h00000, 17'h1FF00, 1'b1, 24'h0,     StatusOutside},
      '{FuncSample, 8'hFF, 17'h1FFFF, 17'h1FFFF, 1'b1, 24'h0,     StatusOutside},
      '{FuncLoad,   8'h01, 17'h1FE00, 17'h1FE00, 1'b0, 24'h0,     StatusOk},
      '{FuncLoad,   8'h80, 17'h1FFFF, 17'h1FE7F, 1'b0, 24'h0,     StatusOk},
      '{FuncLoad,   8'hFE, 17'h1FE01, 17'h1FFFF, 1'b0, 24'h0,     StatusOk},
      '{FuncLoad,   8'h7F, 17'h1FFFF, 17'h1FFFF, 1'b0, 24'h0,     StatusOk},
      '{FuncSample, 8'h00, 17'h1FE80, 17'h1FE40, 1'b0, 24'h0,     StatusOk},
      '{FuncSample, 8'h00, 17'h1FE00, 17'h1FE00, 1'b1, 24'h010000, StatusOk},
      '{FuncLoad,   8'h00, 17'h00000, 17'h00000, 1'b0, 24'h0,     StatusOk},
      '{FuncSample, 8'hFF, 17'h00000, 17'h00000, 1'b1, 24'h0,     StatusOk}
    };
    width_cfg  = DimReset;
    height_cfg = DimReset;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    cfg_check(RegIdxWidth, DimReset);
    cfg_check(RegIdxHeight, DimReset);

    foreach (dir_rows[i]) begin
      c.func        = dir_rows[i].func;
      c.pixel_value = dir_rows[i].pix;
      c.x_pos       = dir_rows[i].x;
      c.y_pos       = dir_rows[i].y;
      tr.sample_value  = dir_rows[i].val;
      tr.sample_status = dir_rows[i].status;
      issue(c, dir_rows[i].typed, tr);
    end

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain();
        while (busy) @(negedge clk_i);
        repeat (12) @(negedge clk_i);
        cfg_write(RegIdxWidth, (ph_w[p] < 0) ? $urandom_range(512, 2) : ph_w[p]);
        cfg_write(RegIdxHeight, (ph_h[p] < 0) ? $urandom_range(512, 2) : ph_h[p]);
        cfg_check(RegIdxWidth, width_cfg);
        cfg_check(RegIdxHeight, height_cfg);
      end
      idle_on = (p != 2);
      run_random(PhaseItems);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (pending_samples.size() != 0)
      log_mismatch("samples never returned", 0, pending_samples.size());
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    bis_res_t want;
    if (rst_ni && done_o) begin
      if (pending_samples.size() == 0) begin
        log_mismatch("word with no sample pending", 0, result_o);
      end else begin
        want = pending_samples.pop_front();
        if (result_o.sample_value !== want.sample_value)
          log_mismatch("sample_value", want.sample_value, result_o.sample_value);
        if (result_o.sample_status !== want.sample_status)
          log_mismatch("sample_status", want.sample_status, result_o.sample_status);
      end
    end
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/bis_pkg.sv
rtl/bis_pix_mem.sv
rtl/bis_blend.sv
rtl/bilinear_image_sampler_core.sv
rtl/bis_checker.sv
tb/tb_top.sv
